// ----- sv/t9_keypad_pattern_matcher_defines.svh -----
// ----------------------------------------------------------------------------
// Keypad pattern matcher assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef T9_KEYPAD_PATTERN_MATCHER_DEFINES_SVH
`define T9_KEYPAD_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define T9KPM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("t9kpm: same-cycle check failed");

// next-cycle implication, checked outside reset
`define T9KPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("t9kpm: next-cycle check failed");

`endif

// ----- sv/t9kpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Keypad pattern matcher package
// Sizes, register indexes, cell control types and the keypad digit compare.
// ----------------------------------------------------------------------------
`default_nettype none

package t9kpm_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int DIGIT_W     = 4;
  localparam int PAT_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_DIGITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLED = 2'd3;

  localparam logic MODE_RUN   = 1'b0;
  localparam logic MODE_ORDER = 1'b1;

  localparam logic [7:0]         CHAR_ZERO = 8'h30;
  localparam logic [7:0]         CHAR_PLUS = 8'h2b;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // first letter and letter count of each key, digits 0 to 9
  localparam logic [7:0] KEY_FIRST [10] = '{8'h00, 8'h00, 8'h61, 8'h64, 8'h67,
                                            8'h6a, 8'h6d, 8'h70, 8'h74, 8'h77};
  localparam logic [7:0] KEY_COUNT [10] = '{8'd0, 8'd0, 8'd3, 8'd3, 8'd3,
                                            8'd3, 8'd3, 8'd4, 8'd3, 8'd4};

  typedef struct packed {
    logic update;   // run mode word taken with a non-empty pattern
    logic clear;    // final word of the string taken
    logic enable;   // this cell lies inside the pattern length
  } cell_ctrl_t;

  typedef struct packed {
    logic hit;          // word matches this cell's digit
    logic active_next;  // run bit this cell takes on update
    logic active;       // registered run bit handed to the next cell
  } cell_stat_t;

  function automatic logic digit_hit(logic [7:0] c, logic [DIGIT_W-1:0] d);
    logic hit;
    hit = 1'b0;
    if (d <= DIGIT_MAX) begin
      if (c == CHAR_ZERO + {4'h0, d}) hit = 1'b1;
      if (d == '0 && c == CHAR_PLUS) hit = 1'b1;
      if (KEY_COUNT[d] != 8'd0 && c >= KEY_FIRST[d] &&
          c < KEY_FIRST[d] + KEY_COUNT[d]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- sv/t9_keypad_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// Keypad digit pattern matcher
// Output: found is registered in the result buffer once the final word of a string is taken.
// Throughput: one word per cycle while item_stall is low; run mode updates sixteen
//   match cells in parallel from their neighbors' run bits, order mode steps progress.
// Reset: rst clears configuration, cell run bits, progress and the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module t9_keypad_pattern_matcher (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic [7:0]                       character,
  input  wire logic                             end_of_string,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic                                  found,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [t9kpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [t9kpm_pkg::PAT_W-1:0]      cfg_data
);
  import t9kpm_pkg::*;

  logic [PAT_W-1:0] pattern_digits;
  logic [LEN_W-1:0] pattern_length;
  logic             search_mode;
  logic             filter_enabled;

  logic [LEN_W-1:0] order_progress;
  logic [LEN_W-1:0] order_progress_next;
  logic             seen_match;
  logic             seen_match_next;

  logic [LEN_W-1:0] len;
  logic             len_zero;
  logic [IDX_W-1:0] last_idx;
  logic             accept;
  logic             buf_full;
  logic             found_next;

  cell_ctrl_t             cell_ctrl [PATTERN_MAX];
  cell_stat_t             cell_stat [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit_vec;
  logic [PATTERN_MAX-1:0] run_next_vec;
  logic [PATTERN_MAX:0]   chain;

  assign cfg_ready  = 1'b1;
  assign item_stall = buf_full;
  assign accept     = item_valid & ~item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_digits <= '0;
      pattern_length <= '0;
      search_mode    <= MODE_RUN;
      filter_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_DIGITS: pattern_digits <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_SEARCH_MODE:    search_mode    <= cfg_data[0];
        REG_FILTER_ENABLED: filter_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp the length to the number of cells
  always_comb begin
    len      = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                      : pattern_length;
    len_zero = (len == '0);
    last_idx = IDX_W'(len - LEN_W'(1));
  end

  assign chain[0] = 1'b1;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    assign cell_ctrl[k] = '{
      update: accept & ~len_zero & (search_mode == MODE_RUN),
      clear:  accept & end_of_string,
      enable: (LEN_W'(k) < len)
    };

    t9kpm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl[k]),
      .character   (character),
      .digit       (pattern_digits[k*DIGIT_W +: DIGIT_W]),
      .prev_active (chain[k]),
      .stat        (cell_stat[k])
    );

    assign chain[k+1]      = cell_stat[k].active;
    assign hit_vec[k]      = cell_stat[k].hit;
    assign run_next_vec[k] = cell_stat[k].active_next;
  end

  always_comb begin
    order_progress_next = order_progress;
    seen_match_next     = seen_match;
    if (!len_zero) begin
      if (search_mode == MODE_RUN) begin
        if (run_next_vec[last_idx]) seen_match_next = 1'b1;
      end else begin
        // progress below len keeps the index inside the cell row
        if (order_progress < len && hit_vec[order_progress[IDX_W-1:0]]) begin
          order_progress_next = order_progress + LEN_W'(1);
        end
        if (order_progress_next >= len) seen_match_next = 1'b1;
      end
    end
    found_next = ~filter_enabled | len_zero | seen_match_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_progress <= '0;
      seen_match     <= 1'b0;
    end else if (accept) begin
      if (end_of_string) begin
        order_progress <= '0;
        seen_match     <= 1'b0;
      end else begin
        order_progress <= order_progress_next;
        seen_match     <= seen_match_next;
      end
    end
  end

  t9kpm_result_buf u_result_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept & end_of_string),
    .push_found   (found_next),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found)
  );

endmodule

`default_nettype wire

// ----- sv/t9kpm_cell.sv -----
// ----------------------------------------------------------------------------
// Keypad pattern matcher cell
// Holds one run bit and matches one pattern digit against the current word.
// ----------------------------------------------------------------------------
`default_nettype none

module t9kpm_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire t9kpm_pkg::cell_ctrl_t          ctrl,
  input  wire logic [7:0]                     character,
  input  wire logic [t9kpm_pkg::DIGIT_W-1:0]  digit,
  input  wire logic                           prev_active,
  output t9kpm_pkg::cell_stat_t               stat
);
  import t9kpm_pkg::*;

  logic active;
  logic active_next;
  logic hit;

  always_comb begin
    hit         = digit_hit(character, digit);
    active_next = ctrl.enable & prev_active & hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctrl.clear) begin
      active <= 1'b0;
    end else if (ctrl.update) begin
      active <= active_next;
    end
  end

  assign stat = '{hit: hit, active_next: active_next, active: active};

endmodule

`default_nettype wire

// ----- sv/t9kpm_result_buf.sv -----
// ----------------------------------------------------------------------------
// Keypad pattern matcher result buffer
// Output register plus skid stage for the found word.
// ----------------------------------------------------------------------------
`default_nettype none

module t9kpm_result_buf (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire logic push_found,
  output logic      full,
  output logic      result_valid,
  input  wire logic result_stall,
  output logic      found
);
  import t9kpm_pkg::*;

  logic out_valid;
  logic out_found;
  logic skid_valid;
  logic skid_found;
  logic pop;

  assign pop = out_valid & ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid  <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload follows the same steering as the valid bits
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_found  <= skid_found;
        skid_found <= push_found;
      end else begin
        out_found  <= push_found;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_found  <= push_found;
      end else begin
        skid_found <= push_found;
      end
    end
  end

  assign full         = skid_valid;
  assign result_valid = out_valid;
  assign found        = out_found;

endmodule

`default_nettype wire

// ----- sv/t9kpm_checker.sv -----
// ----------------------------------------------------------------------------
// Keypad pattern matcher port checker
// Watches the handshakes at the top level ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "t9_keypad_pattern_matcher_defines.svh"

module t9kpm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic item_valid,
  input wire logic item_stall,
  input wire logic end_of_string,
  input wire logic result_valid,
  input wire logic result_stall,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);

  logic last_taken;

  assign last_taken = item_valid & ~item_stall & end_of_string;

  // a stalled result word stays offered
  `T9KPM_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid)

  // no result word appears without a final word taken before it
  `T9KPM_ASSERT_NEXT(a_no_spurious, clk, rst, !result_valid && !last_taken, !result_valid)

  // a final word taken into an empty buffer shows up on the next cycle
  `T9KPM_ASSERT_NEXT(a_result_due, clk, rst, !result_valid && last_taken, result_valid)

  // input only stalls behind a waiting result word
  `T9KPM_ASSERT_NOW(a_stall_cause, clk, rst, item_stall, result_valid)

  // configuration writes are never held off
  `T9KPM_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

endmodule

bind t9_keypad_pattern_matcher t9kpm_checker u_checker (.*);

`default_nettype wire
